### rtl/core/pwm_output_binding_table_unit_defines.svh
// Assertion macros shared by the binding table RTL.
`ifndef PWM_OUTPUT_BINDING_TABLE_UNIT_DEFINES_SVH
`define PWM_OUTPUT_BINDING_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define POBT_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define POBT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pobt_pkg.sv
// Types, constants and helper functions of the output binding table.
package pobt_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLICE_COUNT = 8;
   localparam int PIN_COUNT   = 32;

   localparam int CMD_W    = 2;
   localparam int PIN_W    = 5;
   localparam int RATE_W   = 16;
   localparam int PULSE_W  = 16;
   localparam int WRAP_W   = 16;
   localparam int SLICE_OUT_W = 3;

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int SLICE_W = (SLICE_COUNT > 1) ? $clog2(SLICE_COUNT) : 1;

   // pin compare width covers PIN_COUNT up to 127
   localparam int PIN_CMP_W = 7;
   localparam logic [PIN_CMP_W-1:0] PIN_LIMIT = PIN_CMP_W'(PIN_COUNT);

   // serial divide of the tick rate by the frame rate
   localparam int QUO_W   = 20;
   localparam int QCNT_W  = $clog2(QUO_W + 1);
   localparam logic [QUO_W-1:0] TICKS_PER_SEC = QUO_W'(1000000);
   localparam logic [QUO_W-1:0] MAX_PERIOD    = QUO_W'(65536);
   localparam logic [QUO_W-1:0] MIN_PERIOD    = QUO_W'(2);

   localparam logic [CMD_W-1:0] CMD_BIND    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd2;

   localparam int PAIR_COUNT = 2 ** (PIN_W - 1);

   typedef struct packed {
      logic [PIN_W-1:0]  pin;
      logic [RATE_W-1:0] rate;
      logic [WRAP_W-1:0] wrap;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef logic [PAIR_COUNT-1:0][SLICE_W-1:0] slice_lut_type;

   function automatic slice_lut_type build_slice_lut();
      slice_lut_type t;
      for (int i = 0; i < PAIR_COUNT; i++) begin
         t[i] = SLICE_W'(i % SLICE_COUNT);
      end
      return t;
   endfunction

   localparam slice_lut_type SLICE_LUT = build_slice_lut();

   // slice = (pin >> 1) mod SLICE_COUNT, looked up
   function automatic logic [SLICE_W-1:0] slice_of(logic [PIN_W-1:0] pin);
      return SLICE_LUT[pin[PIN_W-1:1]];
   endfunction

endpackage

### rtl/core/pobt_slot_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pobt_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pobt_div.sv
// Restoring serial divider: tick rate over frame rate, one quotient bit a cycle.
module pobt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pobt_pkg::RATE_W-1:0] divisor,
   output logic                        done,
   output logic [pobt_pkg::QUO_W-1:0]  quotient
);
   import pobt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] div_ff, div_in;
   logic [RATE_W:0]   rem_shift;
   logic              ge;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[QUO_W-1]};
      ge        = (rem_shift >= {1'b0, div_ff});
      busy_in   = busy_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         dvd_in  = TICKS_PER_SEC;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         dvd_in = {dvd_ff[QUO_W-2:0], ge};
         rem_in = ge ? RATE_W'(rem_shift - {1'b0, div_ff}) : RATE_W'(rem_shift);
         cnt_in = cnt_ff + QCNT_W'(1);
         if (cnt_ff == QCNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

### rtl/core/pwm_output_binding_table_unit.sv
// Top level of the output pin binding table: sequencer, slot scan and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  req     | in        | req_valid / req_stall | req_cmd, req_pin, req_rate_hz, req_pulse_us
//  rsp     | out       | rsp_valid / rsp_stall | rsp_accepted ... rsp_level (one per item)
//
// An item runs from acceptance through the serial divide, which hides the 16-slot
// scan and its read latency, then enters decide and loads the result register;
// req_stall drops with that load, so a new item is taken only once the last result is loaded.
// Reset clears the slot valid bits at once; no clearing pass of the RAM.
// A result waiting under rsp_stall does not block the next item; only a
// second finished result waiting behind it holds the decide step.
`include "pwm_output_binding_table_unit_defines.svh"

module pwm_output_binding_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pobt_pkg::CMD_W-1:0]       req_cmd,
   input  logic [pobt_pkg::PIN_W-1:0]       req_pin,
   input  logic [pobt_pkg::RATE_W-1:0]      req_rate_hz,
   input  logic [pobt_pkg::PULSE_W-1:0]     req_pulse_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_accepted,
   output logic [pobt_pkg::SLICE_OUT_W-1:0] rsp_slice_index,
   output logic                             rsp_start_slice,
   output logic [pobt_pkg::WRAP_W-1:0]      rsp_slice_wrap,
   output logic                             rsp_stop_slice,
   output logic                             rsp_release_pin,
   output logic                             rsp_level_valid,
   output logic [pobt_pkg::WRAP_W-1:0]      rsp_level
);
   import pobt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0] state_ff, state_in;

   // captured item
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [PIN_W-1:0]   pin_ff, pin_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;

   // slot scan
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic              rd_used_ff, rd_used_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_idx_ff, hit_idx_in;
   logic [RATE_W-1:0] hit_rate_ff, hit_rate_in;
   logic [WRAP_W-1:0] hit_wrap_ff, hit_wrap_in;
   logic              conflict_ff, conflict_in;
   logic              shared_ff, shared_in;
   logic              free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;

   logic [SLOT_COUNT-1:0] used_ff, used_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   acc_ff, acc_in;
   logic [SLICE_OUT_W-1:0] sidx_ff, sidx_in;
   logic                   start_ff, start_in;
   logic [WRAP_W-1:0]      swrap_ff, swrap_in;
   logic                   stop_ff, stop_in;
   logic                   rel_ff, rel_in;
   logic                   lvalid_ff, lvalid_in;
   logic [WRAP_W-1:0]      level_ff, level_in;

   // RAM and divider hookup
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   slot_entry_type    ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   slot_entry_type    ram_rd_data;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;

   logic              accept;
   logic              scan_done;
   logic              out_free;
   logic              commit;
   logic              pin_ok;
   logic              wrap_ok;
   logic [WRAP_W-1:0] wrap_val;
   logic              rd_slice_eq;
   logic              do_bind, do_rel, do_write, rebind_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_done = (scan_cnt_ff == CNT_W'(SLOT_COUNT)) && !rd_pend_ff;
   assign commit    = (state_ff == ST_DECIDE) && out_free;

   pobt_slot_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (ENTRY_W),
      .ADDR_W(SLOT_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   pobt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .divisor (req_rate_hz),
      .done    (div_done),
      .quotient(div_quo)
   );

   // Issue one slot read a cycle while scanning.
   always_comb begin
      ram_rd_en   = (state_ff == ST_RUN) && (scan_cnt_ff != CNT_W'(SLOT_COUNT));
      ram_rd_addr = scan_cnt_ff[SLOT_W-1:0];
   end

   assign rd_slice_eq = (slice_of(ram_rd_data.pin) == slice_ff);

   // Bind checks: period from the divider, wrap = period - 1.
   always_comb begin
      pin_ok   = ({2'b00, pin_ff} < PIN_LIMIT);
      wrap_ok  = (rate_ff != '0) && (div_quo >= MIN_PERIOD) && (div_quo <= MAX_PERIOD);
      wrap_val = WRAP_W'(div_quo - QUO_W'(1));
      do_bind   = 1'b0;
      rebind_ok = 1'b0;
      do_rel    = 1'b0;
      do_write  = 1'b0;
      case (cmd_ff)
         CMD_BIND: begin
            if (pin_ok && wrap_ok) begin
               if (hit_ff) begin
                  rebind_ok = (hit_rate_ff == rate_ff);
               end else if (!conflict_ff && free_ok_ff) begin
                  do_bind = 1'b1;
               end
            end
         end
         CMD_RELEASE: begin
            do_rel = pin_ok && hit_ff;
         end
         CMD_WRITE: begin
            do_write = pin_ok && hit_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ram_wr_en        = commit && do_bind;
      ram_wr_addr      = free_idx_ff;
      ram_wr_data.pin  = pin_ff;
      ram_wr_data.rate = rate_ff;
      ram_wr_data.wrap = wrap_val;
   end

   // Sequencer and scan accumulation.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      pin_in      = pin_ff;
      rate_in     = rate_ff;
      pulse_in    = pulse_ff;
      slice_in    = slice_ff;
      scan_cnt_in = scan_cnt_ff;
      rd_pend_in  = 1'b0;
      rd_idx_in   = rd_idx_ff;
      rd_used_in  = rd_used_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rate_in = hit_rate_ff;
      hit_wrap_in = hit_wrap_ff;
      conflict_in = conflict_ff;
      shared_in   = shared_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      used_in     = used_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // capture the item and clear the scan results
               cmd_in      = req_cmd;
               pin_in      = req_pin;
               rate_in     = req_rate_hz;
               pulse_in    = req_pulse_us;
               slice_in    = slice_of(req_pin);
               scan_cnt_in = '0;
               hit_in      = 1'b0;
               conflict_in = 1'b0;
               shared_in   = 1'b0;
               free_ok_in  = 1'b0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ram_rd_en) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
               rd_idx_in   = ram_rd_addr;
               rd_used_in  = used_ff[ram_rd_addr];
            end
            if (rd_pend_ff) begin
               if (!rd_used_ff) begin
                  // take the lowest free slot
                  if (!free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = rd_idx_ff;
                  end
               end else begin
                  if (ram_rd_data.pin == pin_ff && !hit_ff) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = rd_idx_ff;
                     hit_rate_in = ram_rd_data.rate;
                     hit_wrap_in = ram_rd_data.wrap;
                  end
                  if (rd_slice_eq && ram_rd_data.rate != rate_ff) begin
                     conflict_in = 1'b1;
                  end
                  if (rd_slice_eq && ram_rd_data.pin != pin_ff) begin
                     shared_in = 1'b1;
                  end
               end
            end
            if (scan_done && div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold until the result register can take the item
            if (commit) begin
               if (do_bind) begin
                  used_in[free_idx_ff] = 1'b1;
               end
               if (do_rel) begin
                  used_in[hit_idx_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      sidx_in      = sidx_ff;
      start_in     = start_ff;
      swrap_in     = swrap_ff;
      stop_in      = stop_ff;
      rel_in       = rel_ff;
      lvalid_in    = lvalid_ff;
      level_in     = level_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         acc_in       = do_bind || rebind_ok || do_rel || do_write;
         sidx_in      = SLICE_OUT_W'(slice_ff);
         start_in     = do_bind;
         swrap_in     = do_bind ? wrap_val : '0;
         stop_in      = do_rel && !shared_ff;
         rel_in       = do_rel;
         lvalid_in    = do_bind || do_rel || do_write;
         // clamp the pulse to the wrap on write
         if (do_write) begin
            level_in = (pulse_ff > hit_wrap_ff) ? hit_wrap_ff : pulse_ff;
         end else begin
            level_in = '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pin_ff      <= pin_in;
      rate_ff     <= rate_in;
      pulse_ff    <= pulse_in;
      slice_ff    <= slice_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      rd_used_ff  <= rd_used_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rate_ff <= hit_rate_in;
      hit_wrap_ff <= hit_wrap_in;
      conflict_ff <= conflict_in;
      shared_ff   <= shared_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      acc_ff      <= acc_in;
      sidx_ff     <= sidx_in;
      start_ff    <= start_in;
      swrap_ff    <= swrap_in;
      stop_ff     <= stop_in;
      rel_ff      <= rel_in;
      lvalid_ff   <= lvalid_in;
      level_ff    <= level_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_slice_index = sidx_ff;
   assign rsp_start_slice = start_ff;
   assign rsp_slice_wrap  = swrap_ff;
   assign rsp_stop_slice  = stop_ff;
   assign rsp_release_pin = rel_ff;
   assign rsp_level_valid = lvalid_ff;
   assign rsp_level       = level_ff;

   `POBT_ASSERT_IMPL(a_start_is_bind, rsp_valid && rsp_start_slice,
      rsp_accepted && rsp_level_valid && !rsp_release_pin,
      "slice start without an accepted bind")
   `POBT_ASSERT_IMPL(a_stop_needs_release, rsp_valid && rsp_stop_slice,
      rsp_release_pin && rsp_accepted, "slice stop without a pin release")
   `POBT_ASSERT_NEXT(a_used_one_step, 1'b1,
      $countones(used_ff) <= $countones($past(used_ff)) + 1,
      "more than one slot taken in a cycle")
   `POBT_ASSERT_NEXT(a_accept_starts_run, accept, state_ff == ST_RUN && !div_done,
      "accepted item did not start the scan and divide")

endmodule

### bench/tb_pwm_output_binding_table_unit.sv
// Self-checking testbench for the PWM output pin binding table.
module tb_pwm_output_binding_table_unit;

   // Command code that the block must ignore.
   localparam logic [pobt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Generous bound on the whole run; a correct run needs far fewer cycles.
   localparam int CYCLE_LIMIT = 500000;

   // Cycles to wait after the last result so that a stray extra result shows up.
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic                             accepted;
      logic [pobt_pkg::SLICE_OUT_W-1:0] slice_index;
      logic                             start_slice;
      logic [pobt_pkg::WRAP_W-1:0]      slice_wrap;
      logic                             stop_slice;
      logic                             release_pin;
      logic                             level_valid;
      logic [pobt_pkg::WRAP_W-1:0]      level;
   } binding_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [pobt_pkg::CMD_W-1:0]       req_cmd = '0;
   logic [pobt_pkg::PIN_W-1:0]       req_pin = '0;
   logic [pobt_pkg::RATE_W-1:0]      req_rate_hz = '0;
   logic [pobt_pkg::PULSE_W-1:0]     req_pulse_us = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_accepted;
   logic [pobt_pkg::SLICE_OUT_W-1:0] rsp_slice_index;
   logic                             rsp_start_slice;
   logic [pobt_pkg::WRAP_W-1:0]      rsp_slice_wrap;
   logic                             rsp_stop_slice;
   logic                             rsp_release_pin;
   logic                             rsp_level_valid;
   logic [pobt_pkg::WRAP_W-1:0]      rsp_level;

   // Shadow copy of the slot table, advanced once per accepted item.
   bit                            bound_used [pobt_pkg::SLOT_COUNT];
   logic [pobt_pkg::PIN_W-1:0]    bound_pin  [pobt_pkg::SLOT_COUNT];
   logic [pobt_pkg::RATE_W-1:0]   bound_rate [pobt_pkg::SLOT_COUNT];
   logic [pobt_pkg::WRAP_W-1:0]   bound_wrap [pobt_pkg::SLOT_COUNT];

   // Results still owed by the block, oldest first.
   binding_result_type pending_results[$];

   int mismatch_count = 0;
   int cycle_count = 0;

   // Idle odds in percent for the sender gaps and the receiver stalls.
   int source_idle_pct = 33;
   int sink_stall_pct = 33;

   pwm_output_binding_table_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pin         (req_pin),
      .req_rate_hz     (req_rate_hz),
      .req_pulse_us    (req_pulse_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_slice_index (rsp_slice_index),
      .rsp_start_slice (rsp_start_slice),
      .rsp_slice_wrap  (rsp_slice_wrap),
      .rsp_stop_slice  (rsp_stop_slice),
      .rsp_release_pin (rsp_release_pin),
      .rsp_level_valid (rsp_level_valid),
      .rsp_level       (rsp_level)
   );

   always #5 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Two pins share a slice; the slice index wraps modulo the slice count.
   function automatic int slice_for_pin(input logic [pobt_pkg::PIN_W-1:0] pin);
      return (int'(pin) >> 1) % pobt_pkg::SLICE_COUNT;
   endfunction

   // Work out the result of one command and advance the shadow slot table.
   function automatic binding_result_type predict_binding(
      input logic [pobt_pkg::CMD_W-1:0]   cmd,
      input logic [pobt_pkg::PIN_W-1:0]   pin,
      input logic [pobt_pkg::RATE_W-1:0]  rate,
      input logic [pobt_pkg::PULSE_W-1:0] pulse
   );
      binding_result_type r;
      int slice;
      int hit;
      int first_open;
      int period;
      bit shared;
      logic [pobt_pkg::WRAP_W-1:0] wrap;
      r = '0;
      slice = slice_for_pin(pin);
      r.slice_index = pobt_pkg::SLICE_OUT_W'(slice);
      hit = -1;
      first_open = -1;
      period = 0;
      shared = 1'b0;
      // Refuse pins beyond the wired pin count.
      if (int'(pin) >= pobt_pkg::PIN_COUNT) return r;
      for (int i = 0; i < pobt_pkg::SLOT_COUNT; i++) begin
         if (hit < 0 && bound_used[i] && bound_pin[i] == pin) hit = i;
      end
      case (cmd)
         pobt_pkg::CMD_BIND: begin
            // Frame period in microsecond ticks; zero rate, overlong period
            // and a zero wrap are all refused.
            if (rate != '0) period = int'(pobt_pkg::TICKS_PER_SEC) / int'(rate);
            if (period <= 1 || period > int'(pobt_pkg::MAX_PERIOD)) return r;
            wrap = pobt_pkg::WRAP_W'(period - 1);
            // A bound pin only passes again at its own rate; nothing is programmed.
            if (hit >= 0) begin
               r.accepted = (bound_rate[hit] == rate);
               return r;
            end
            for (int i = 0; i < pobt_pkg::SLOT_COUNT; i++) begin
               if (!bound_used[i]) begin
                  if (first_open < 0) first_open = i;
               end else if (slice_for_pin(bound_pin[i]) == slice &&
                            bound_rate[i] != rate) begin
                  return r;
               end
            end
            if (first_open < 0) return r;
            bound_used[first_open] = 1'b1;
            bound_pin[first_open] = pin;
            bound_rate[first_open] = rate;
            bound_wrap[first_open] = wrap;
            r.accepted = 1'b1;
            r.start_slice = 1'b1;
            r.slice_wrap = wrap;
            r.level_valid = 1'b1;
         end
         pobt_pkg::CMD_RELEASE: begin
            if (hit < 0) return r;
            for (int i = 0; i < pobt_pkg::SLOT_COUNT; i++) begin
               if (bound_used[i] && i != hit && slice_for_pin(bound_pin[i]) == slice)
                  shared = 1'b1;
            end
            bound_used[hit] = 1'b0;
            r.accepted = 1'b1;
            r.stop_slice = !shared;
            r.release_pin = 1'b1;
            r.level_valid = 1'b1;
         end
         pobt_pkg::CMD_WRITE: begin
            if (hit < 0) return r;
            r.accepted = 1'b1;
            r.level_valid = 1'b1;
            r.level = (pulse > bound_wrap[hit]) ? bound_wrap[hit] : pulse;
         end
         default: begin
            // Unknown command: drop it, state stays.
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string field, input int expected_value,
                                input int actual_value);
      if (expected_value != actual_value) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                  expected_value, actual_value);
      end
   endtask

   // Result side: check every accepted result and stall at random.
   always @(posedge clock) begin
      binding_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no item outstanding, expected none, actual %p",
                        $time, {rsp_accepted, rsp_slice_index, rsp_level});
            end else begin
               want = pending_results.pop_front();
               compare_field("accepted", want.accepted, rsp_accepted);
               compare_field("slice_index", want.slice_index, rsp_slice_index);
               compare_field("start_slice", want.start_slice, rsp_start_slice);
               compare_field("slice_wrap", want.slice_wrap, rsp_slice_wrap);
               compare_field("stop_slice", want.stop_slice, rsp_stop_slice);
               compare_field("release_pin", want.release_pin, rsp_release_pin);
               compare_field("level_valid", want.level_valid, rsp_level_valid);
               compare_field("level", want.level, rsp_level);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
   end

   // Offer one item, hold it until the block takes it, then log its expected result.
   // Valid stays high after acceptance; the next call lowers it only for a gap.
   task automatic send_item(
      input logic [pobt_pkg::CMD_W-1:0]   cmd,
      input logic [pobt_pkg::PIN_W-1:0]   pin,
      input logic [pobt_pkg::RATE_W-1:0]  rate,
      input logic [pobt_pkg::PULSE_W-1:0] pulse
   );
      if ($urandom_range(0, 99) < source_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < source_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pin <= pin;
      req_rate_hz <= rate;
      req_pulse_us <= pulse;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_binding(cmd, pin, rate, pulse));
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Rate limits: zero, just too slow, slowest legal, fastest possible.
   task automatic test_bind_rates();
      send_item(pobt_pkg::CMD_BIND, 5'd0, 16'd0, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd0, 16'd15, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd0, 16'd16, 16'hFFFF);
      send_item(pobt_pkg::CMD_BIND, 5'd31, 16'hFFFF, 16'd0);
   endtask

   // Rebind of a bound pin: same rate passes quietly, another rate is refused.
   task automatic test_rebind();
      send_item(pobt_pkg::CMD_BIND, 5'd0, 16'd16, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd0, 16'd50, 16'd0);
   endtask

   // The partner pin, and a pin that wraps onto slice 0, must match its rate.
   task automatic test_slice_sharing();
      send_item(pobt_pkg::CMD_BIND, 5'd1, 16'd1000, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd16, 16'd1000, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd1, 16'd16, 16'd0);
      send_item(pobt_pkg::CMD_BIND, 5'd17, 16'd16, 16'd0);
   endtask

   // Pulse writes: clamp to the wrap, zero, in range, unbound pin.
   task automatic test_write_clamp();
      send_item(pobt_pkg::CMD_WRITE, 5'd31, 16'd0, 16'hFFFF);
      send_item(pobt_pkg::CMD_WRITE, 5'd0, 16'hFFFF, 16'd0);
      send_item(pobt_pkg::CMD_WRITE, 5'd1, 16'd0, 16'd1234);
      send_item(pobt_pkg::CMD_WRITE, 5'd5, 16'd0, 16'd100);
   endtask

   task automatic test_unknown_cmd();
      send_item(CMD_UNUSED, 5'd0, 16'hFFFF, 16'hFFFF);
      send_item(CMD_UNUSED, 5'd31, 16'd1000, 16'd10);
   endtask

   // Releases: a shared slice keeps running, the only pin of another slice stops it, repeats are refused.
   task automatic test_release();
      send_item(pobt_pkg::CMD_RELEASE, 5'd0, 16'd0, 16'd0);
      send_item(pobt_pkg::CMD_RELEASE, 5'd1, 16'hFFFF, 16'hFFFF);
      send_item(pobt_pkg::CMD_RELEASE, 5'd1, 16'd0, 16'd0);
      send_item(pobt_pkg::CMD_RELEASE, 5'd31, 16'd0, 16'd0);
      send_item(pobt_pkg::CMD_WRITE, 5'd0, 16'd0, 16'd500);
   endtask

   // Random commands with the given mix; the rest are writes, a few unknown codes.
   // Rates mostly come from a small pool so that rebinds and shared slices line up.
   task automatic run_random_mix(input int items, input int bind_pct, input int release_pct);
      logic [pobt_pkg::CMD_W-1:0]   cmd;
      logic [pobt_pkg::RATE_W-1:0]  rate;
      logic [pobt_pkg::PULSE_W-1:0] pulse;
      int roll;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < bind_pct) cmd = pobt_pkg::CMD_BIND;
         else if (roll < bind_pct + release_pct) cmd = pobt_pkg::CMD_RELEASE;
         else if (roll < 95) cmd = pobt_pkg::CMD_WRITE;
         else cmd = CMD_UNUSED;
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 2))
            0: rate = 16'd50;
            1: rate = 16'd400;
            default: rate = 16'd1000;
         endcase
         if (roll >= 90) rate = pobt_pkg::RATE_W'($urandom_range(0, 65535));
         else if (roll >= 80) begin
            case ($urandom_range(0, 3))
               0: rate = 16'd0;
               1: rate = 16'd15;
               2: rate = 16'd16;
               default: rate = 16'hFFFF;
            endcase
         end
         if ($urandom_range(0, 1) != 0) begin
            pulse = pobt_pkg::PULSE_W'($urandom_range(0, 65535));
         end else begin
            pulse = pobt_pkg::PULSE_W'($urandom_range(0, 3000));
         end
         send_item(cmd, pobt_pkg::PIN_W'($urandom_range(0, 31)), rate, pulse);
      end
   endtask

   // Bind-heavy traffic so that the table fills up and further binds are refused.
   task automatic test_table_fill();
      run_random_mix(120, 80, 5);
   endtask

   // Let everything drain in the middle of traffic, then resume.
   task automatic test_drain_pause();
      run_random_mix(30, 40, 30);
      wait_for_drain();
      run_random_mix(30, 40, 30);
   endtask

   // Back-to-back items and an always-ready receiver.
   task automatic test_no_idle_stretch();
      source_idle_pct = 0;
      sink_stall_pct = 0;
      run_random_mix(150, 50, 25);
      source_idle_pct = 33;
      sink_stall_pct = 33;
   endtask

   // Alternate filling and emptying phases so the table sweeps its whole range.
   task automatic test_random_churn();
      for (int phase = 0; phase < 7; phase++) begin
         if (phase % 2 == 0) run_random_mix(100, 70, 10);
         else run_random_mix(100, 20, 50);
      end
   endtask

   initial begin
      // Hold reset, then release it at a rising edge.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bind_rates();
      test_rebind();
      test_slice_sharing();
      test_write_clamp();
      test_unknown_cmd();
      test_release();
      test_table_fill();
      test_drain_pause();
      test_no_idle_stretch();
      test_random_churn();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
